FILE: hdl/bgfb_pkg.sv
// shared types, constants and helpers for the bit granular field buffer
`timescale 1ns / 1ps

package bgfb_pkg;

  // store geometry
  localparam int STORE_BYTES = 4096;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int STORE_BITS  = STORE_BYTES * 8;
  localparam int FIELD_MAX   = 64;
  localparam int WIN_W       = FIELD_MAX + 8;
  localparam int MAX_BYTES   = WIN_W / 8;

  // request codes
  typedef enum logic [2:0] {
    REQ_WRITE  = 3'd0,
    REQ_READ_U = 3'd1,
    REQ_READ_S = 3'd2,
    REQ_ALIGN  = 3'd3,
    REQ_SEEK   = 3'd4
  } req_code_t;

  // status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_SHORT    = 2'd2
  } status_t;

  // one request as taken from the input channel
  typedef struct packed {
    logic [2:0]  req_type;
    logic [6:0]  field_width;
    logic [63:0] write_value;
    logic [15:0] seek_target;
  } req_t;

  // one result as handed to the output register
  typedef struct packed {
    logic [63:0] read_data;
    logic [15:0] cursor;
    logic [12:0] length;
    logic [1:0]  status;
  } res_t;

  // handshake towards the engine
  typedef struct packed {
    logic req_valid;
    logic res_ready;
  } eng_ctl_t;

  // handshake from the engine
  typedef struct packed {
    logic req_ready;
    logic res_valid;
  } eng_sts_t;

  // zero counts as one, anything above the field limit as the limit
  function automatic logic [6:0] clamp_width(input logic [6:0] w);
    logic [6:0] r;
    if (w == 7'd0) begin
      r = 7'd1;
    end else if (w > 7'(FIELD_MAX)) begin
      r = 7'(FIELD_MAX);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

FILE: hdl/bgfb_ram.sv
// byte store: one write port, one read port, registered read data
`timescale 1ns / 1ps

module bgfb_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bgfb_engine.sv
// request sequencer: cursor, length and byte-wise read-modify-write of the store
`timescale 1ns / 1ps

module bgfb_engine (
  input  logic               clk,
  input  logic               rst,
  input  bgfb_pkg::eng_ctl_t ctl,
  input  bgfb_pkg::req_t     req,
  output bgfb_pkg::eng_sts_t sts,
  output bgfb_pkg::res_t     res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WPREP1,
    S_WPREP2,
    S_WPREP3,
    S_RPREP,
    S_ISSUE,
    S_LOOP,
    S_RALIGN,
    S_RSIGN,
    S_DONE
  } state_t;

  localparam logic [63:0] ONES = {64{1'b1}};

  state_t      state;
  logic [15:0] cursor;
  logic [12:0] len;

  logic [2:0]  req_code;
  logic [6:0]  fw;
  logic [63:0] wval;
  logic [16:0] end_pos;
  logic [12:0] new_len;
  logic [6:0]  span;
  logic [6:0]  run_len;
  logic [63:0] vlj;
  logic [bgfb_pkg::WIN_W-1:0] dwin;
  logic [bgfb_pkg::WIN_W-1:0] mwin;
  logic [bgfb_pkg::WIN_W-1:0] acc;
  logic [12:0] addr;
  logic [3:0]  cnt;
  logic [2:0]  sh;
  logic [63:0] fmask;
  logic [63:0] fld;
  logic [63:0] rd_data;
  logic [1:0]  status;

  logic [2:0]  offs;
  logic [15:0] lim_bits;
  logic [15:0] len_bits;
  logic [12:0] addr_inc;
  logic [12:0] end_len;
  logic [6:0]  fw7;
  logic [7:0]  rsum;
  logic [7:0]  wsum;
  logic [7:0]  old_byte;
  logic [7:0]  rdata;
  logic [7:0]  wdata;
  logic        we;
  logic [bgfb_pkg::ADDR_W-1:0] raddr;

  // derived positions
  assign offs     = cursor[2:0];
  assign len_bits = {len, 3'b000};
  assign lim_bits = {new_len, 3'b000} - cursor;
  assign addr_inc = addr + 13'd1;
  assign end_len  = 13'((end_pos + 17'd7) >> 3);
  assign fw7      = fw + 7'd7;
  assign rsum     = 8'(offs) + 8'(fw);
  assign wsum     = 8'(offs) + 8'(run_len) + 8'd7;

  // bytes at or past the used length count as zero
  assign old_byte = (addr < len) ? rdata : 8'h00;
  assign wdata    = (old_byte & ~mwin[bgfb_pkg::WIN_W-1 -: 8]) |
                    (dwin[bgfb_pkg::WIN_W-1 -: 8] & mwin[bgfb_pkg::WIN_W-1 -: 8]);
  assign we       = (state == S_LOOP) && (req_code == bgfb_pkg::REQ_WRITE);

  // read ahead by one byte while the loop writes the current one
  assign raddr = (state == S_LOOP) ? addr_inc[bgfb_pkg::ADDR_W-1:0]
                                   : addr[bgfb_pkg::ADDR_W-1:0];

  bgfb_ram #(
    .ADDR_W(bgfb_pkg::ADDR_W),
    .DATA_W(8)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(addr[bgfb_pkg::ADDR_W-1:0]),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // handshake and result
  assign sts.req_ready = (state == S_IDLE);
  assign sts.res_valid = (state == S_DONE);
  assign res.read_data = rd_data;
  assign res.cursor    = cursor;
  assign res.length    = len;
  assign res.status    = status;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cursor <= 16'd0;
      len    <= 13'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.req_valid) begin
            req_code <= req.req_type;
            fw       <= bgfb_pkg::clamp_width(req.field_width);
            wval     <= req.write_value;
            rd_data  <= 64'd0;
            status   <= bgfb_pkg::ST_OK;
            unique case (req.req_type)
              bgfb_pkg::REQ_WRITE: begin
                state <= S_WPREP1;
              end
              bgfb_pkg::REQ_READ_U, bgfb_pkg::REQ_READ_S: begin
                state <= S_RPREP;
              end
              bgfb_pkg::REQ_ALIGN: begin
                cursor <= (cursor + 16'd7) & ~16'd7;
                state  <= S_DONE;
              end
              bgfb_pkg::REQ_SEEK: begin
                cursor <= (req.seek_target > len_bits) ? len_bits : req.seek_target;
                state  <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        // field end, chunk span and left-justified value
        S_WPREP1: begin
          end_pos <= {1'b0, cursor} + 17'(fw);
          span    <= {fw7[6:3], 3'b000};
          vlj     <= wval << (7'(bgfb_pkg::FIELD_MAX) - fw);
          state   <= S_WPREP2;
        end
        // capacity check and new length
        S_WPREP2: begin
          if (end_pos > 17'(bgfb_pkg::STORE_BITS)) begin
            status <= bgfb_pkg::ST_OVERFLOW;
            state  <= S_DONE;
          end else begin
            new_len <= (len > end_len) ? len : end_len;
            addr    <= 13'(cursor[15:3]);
            state   <= S_WPREP3;
          end
        end
        // padding stops at the new length
        S_WPREP3: begin
          run_len <= ({9'd0, span} < lim_bits) ? span : lim_bits[6:0];
          dwin    <= {vlj, 8'h00} >> offs;
          state   <= S_ISSUE;
        end
        S_RPREP: begin
          addr    <= 13'(cursor[15:3]);
          cnt     <= 4'((rsum + 8'd7) >> 3);
          sh      <= 3'd0 - rsum[2:0];
          end_pos <= {1'b0, cursor} + 17'(fw);
          acc     <= '0;
          state   <= S_ISSUE;
        end
        // first byte read goes out here
        S_ISSUE: begin
          if (req_code == bgfb_pkg::REQ_WRITE) begin
            mwin <= {~(ONES >> run_len), 8'h00} >> offs;
            cnt  <= 4'(wsum >> 3);
          end
          state <= S_LOOP;
        end
        // one byte per cycle
        S_LOOP: begin
          if (req_code == bgfb_pkg::REQ_WRITE) begin
            dwin <= dwin << 8;
            mwin <= mwin << 8;
          end else begin
            acc <= {acc[bgfb_pkg::WIN_W-9:0], old_byte};
          end
          addr <= addr_inc;
          cnt  <= cnt - 4'd1;
          if (cnt == 4'd1) begin
            if (req_code == bgfb_pkg::REQ_WRITE) begin
              cursor <= end_pos[15:0];
              len    <= new_len;
              state  <= S_DONE;
            end else begin
              state <= S_RALIGN;
            end
          end
        end
        // drop trailing bits, mask to width, clamp cursor
        S_RALIGN: begin
          fmask <= ONES >> (7'(bgfb_pkg::FIELD_MAX) - fw);
          fld   <= 64'(acc >> sh) & (ONES >> (7'(bgfb_pkg::FIELD_MAX) - fw));
          if (end_pos > {1'b0, len_bits}) begin
            cursor <= len_bits;
            status <= bgfb_pkg::ST_SHORT;
          end else begin
            cursor <= end_pos[15:0];
          end
          state <= S_RSIGN;
        end
        // sign extension
        S_RSIGN: begin
          if ((req_code == bgfb_pkg::REQ_READ_S) && fld[6'(fw - 7'd1)]) begin
            rd_data <= fld | ~fmask;
          end else begin
            rd_data <= fld;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (ctl.res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // cursor stays within the used bits
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= len_bits)
    else $error("cursor beyond used length");

  // writes stay inside the new used length
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> addr < new_len)
    else $error("store write beyond used length");

  // byte loop count is within one field span
  a_loop_count: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOP |-> (cnt != 4'd0) && (cnt <= 4'(bgfb_pkg::MAX_BYTES)))
    else $error("byte loop count out of range");

  // used length never shrinks
  a_len_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> len >= $past(len))
    else $error("used length decreased");
`endif

endmodule

FILE: hdl/bit_granular_field_buffer.sv
// top level: request and result channels around the field buffer engine
`timescale 1ns / 1ps

// Bit granular field buffer: a 4096-byte store with a bit cursor and a used
// length, taking one request at a time (write, read unsigned, read signed,
// align, seek). A read or write runs through its preparation states and then a
// byte loop over the n store bytes the field spans (1 to 9); the byte loop
// is set by the byte-wide store, which does one read and one write per cycle.
// Align, seek and unused codes go from idle straight to the result, and a
// write refused at capacity ends at the capacity check.
// A finished result sits in an output register, so the next request is taken
// while it waits. The store needs no clearing pass after reset: bytes at or
// past the used length read as zero, and every byte brought into use is
// written in full.
module bit_granular_field_buffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [6:0]  field_width,
  input  logic [63:0] write_value,
  input  logic [15:0] seek_target,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] read_data,
  output logic [15:0] cursor_after,
  output logic [12:0] used_length,
  output logic [1:0]  status_code
);

  bgfb_pkg::eng_ctl_t ctl;
  bgfb_pkg::eng_sts_t sts;
  bgfb_pkg::req_t     req;
  bgfb_pkg::res_t     res;
  logic               load;

  // request side
  assign req.req_type    = req_type;
  assign req.field_width = field_width;
  assign req.write_value = write_value;
  assign req.seek_target = seek_target;
  assign ctl.req_valid   = in_valid;
  assign in_ready        = sts.req_ready;

  // output register frees up when empty or being drained
  assign ctl.res_ready = !out_valid || out_ready;
  assign load          = sts.res_valid && ctl.res_ready;

  bgfb_engine u_engine (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .req(req),
    .sts(sts),
    .res(res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      read_data    <= res.read_data;
      cursor_after <= res.cursor;
      used_length  <= res.length;
      status_code  <= res.status;
    end
  end

endmodule
